>>> src/mfh_pkg.sv
// Package for the MQTT fixed header parser: item types, check codes and the flag check.
// Used by every module of the parser; depends on nothing else.
`default_nettype none

package mfh_pkg;

  localparam int MaxLengthBytesDef = 4;

  localparam logic [3:0] PktPublish = 4'd3;
  localparam logic [3:0] PktPubrel  = 4'd6;
  localparam logic [3:0] PktSubscr  = 4'd8;
  localparam logic [3:0] PktUnsub   = 4'd10;
  localparam logic [3:0] FlagsFixed = 4'd2;
  localparam logic [1:0] QosMalf    = 2'd3;
  localparam logic [1:0] QosZero    = 2'd0;

  typedef enum logic [1:0] {
    CodeOk        = 2'd0,
    CodeMalformed = 2'd1,
    CodeRetain    = 2'd2,
    CodeQos       = 2'd3
  } check_code_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       header_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  packet_type;
    logic [1:0]  check_code;
    logic [27:0] remaining_length;
    logic [2:0]  length_bytes;
  } out_item_t;

  // Flag check for a server that only supports QoS 0.
  function automatic check_code_e flag_check(input logic [3:0] ptype, input logic [3:0] flags);
    check_code_e code;
    if (flags == 4'd0) begin
      code = CodeOk;
    end else if ((ptype == PktPubrel || ptype == PktSubscr || ptype == PktUnsub) &&
                 flags == FlagsFixed) begin
      code = CodeOk;
    end else if (ptype == PktPublish) begin
      if (flags[0]) begin
        code = CodeRetain;
      end else if (flags[2:1] == QosMalf) begin
        code = CodeMalformed;
      end else if (flags[2:1] != QosZero) begin
        code = CodeQos;
      end else if (flags[3]) begin
        code = CodeMalformed;
      end else begin
        code = CodeOk;
      end
    end else begin
      code = CodeMalformed;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

>>> src/mfh_in_stage.sv
// Input register of the MQTT fixed header parser.
// Depends on mfh_pkg for the input item type.
`default_nettype none

module mfh_in_stage
  import mfh_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          held_valid_o,
  output in_item_t      held_item_o,
  input  wire logic     held_take_i
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // The register can load whenever it is empty or its item leaves this cycle.
  assign in_stall_o = valid_q && !held_take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (held_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

endmodule

`default_nettype wire

>>> src/mfh_core.sv
// Header state, length decoding and result register of the MQTT fixed header parser.
// Depends on mfh_pkg for item types and the flag check.
`default_nettype none

module mfh_core
  import mfh_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MaxLengthBytesDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     held_valid_i,
  input  wire in_item_t held_item_i,
  output logic          held_take_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  localparam logic [2:0] MaxCnt = 3'(MAX_LENGTH_BYTES);

  logic        in_field_q, in_field_d;
  logic [3:0]  type_q, type_d;
  logic [1:0]  code_q, code_d;
  logic [27:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        advance;
  logic        step;
  logic        emit;
  logic [27:0] part_shifted;

  // The result register frees up when empty or when its item is taken.
  assign advance     = !out_valid_q || !out_stall_i;
  assign held_take_o = held_valid_i && advance;
  assign step        = held_take_o;

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    part_shifted = {21'd0, held_item_i.data_byte[6:0]};
      2'd1:    part_shifted = {14'd0, held_item_i.data_byte[6:0], 7'd0};
      2'd2:    part_shifted = {7'd0, held_item_i.data_byte[6:0], 14'd0};
      default: part_shifted = {held_item_i.data_byte[6:0], 21'd0};
    endcase
  end

  always_comb begin
    in_field_d = in_field_q;
    type_d     = type_q;
    code_d     = code_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    emit       = 1'b0;
    if (step) begin
      if (held_item_i.header_start) begin
        type_d     = held_item_i.data_byte[7:4];
        code_d     = 2'(flag_check(held_item_i.data_byte[7:4], held_item_i.data_byte[3:0]));
        acc_d      = 28'd0;
        cnt_d      = 3'd0;
        in_field_d = 1'b1;
      end else if (in_field_q) begin
        if (cnt_q < 3'd4) begin
          acc_d = acc_q + part_shifted;
        end
        cnt_d = cnt_q + 3'd1;
        if (!held_item_i.data_byte[7] || cnt_d >= MaxCnt) begin
          emit       = 1'b1;
          in_field_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_d.packet_type      = type_q;
      out_d.check_code       = code_q;
      out_d.remaining_length = acc_d;
      out_d.length_bytes     = cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_field_q  <= 1'b0;
      type_q      <= 4'd0;
      code_q      <= 2'd0;
      acc_q       <= 28'd0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      in_field_q  <= in_field_d;
      type_q      <= type_d;
      code_q      <= code_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> src/mqtt_fixed_header_parser_top.sv
// MQTT fixed header parser, top level. Depends on mfh_pkg, mfh_in_stage and mfh_core.
// Flow: a byte accepted into the input register waits there until the result register
// can advance; the header logic then folds it in, and a result it completes lands in the
// result register. Throughput: one byte per cycle, sustained, while out_stall_i is low.
// Reset (rst_ni low, asynchronous) empties both registers and leaves the parser idle.
`default_nettype none

module mqtt_fixed_header_parser_top
  import mfh_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = MaxLengthBytesDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_item_o
);

  logic     held_valid;
  in_item_t held_item;
  logic     held_take;

  // The input register decouples the byte stream from the header logic; while a finished
  // result waits downstream, a new item is taken only if the input register is empty.
  mfh_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .held_valid_o (held_valid),
    .held_item_o  (held_item),
    .held_take_i  (held_take)
  );

  // The core keeps the header state: packet type, check code, the partial length and
  // the count of length bytes. A start mark always restarts the header; bytes without
  // it are ignored while idle. The field closes on a byte with bit 7 clear or on the
  // last allowed length byte, and the finished header lands in the result register.
  mfh_core #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .held_valid_i (held_valid),
    .held_item_i  (held_item),
    .held_take_o  (held_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire
